// ===== hw/rtl/u8bsd_pkg.sv =====
// Shared constants for the UTF-8 byte stream decoder.
`default_nettype none

package u8bsd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 3;

  // Lead byte class boundaries
  localparam logic [ByteW-1:0] LeadTwoLo   = 8'd192;
  localparam logic [ByteW-1:0] LeadThreeLo = 8'd224;
  localparam logic [ByteW-1:0] LeadFourLo  = 8'd240;
  localparam logic [ByteW-1:0] LeadBadLo   = 8'd248;

  // Continuation byte pattern on the top two bits
  localparam logic [1:0] ContTag = 2'b10;

  localparam logic [CountW-1:0] LenNone  = 3'd0;
  localparam logic [CountW-1:0] LenOne   = 3'd1;
  localparam logic [CountW-1:0] LenTwo   = 3'd2;
  localparam logic [CountW-1:0] LenThree = 3'd3;
  localparam logic [CountW-1:0] LenFour  = 3'd4;

endpackage : u8bsd_pkg

`default_nettype wire

// ===== hw/rtl/utf8_byte_stream_decoder.sv =====
// UTF-8 byte stream decoder: one byte in per word, code points or errors out.
`default_nettype none

// One byte is taken per cycle. The sequence state (gathered payload, open
// length, bytes held) is updated when a byte is accepted, and the results
// that byte causes are written into a result register in the same cycle: a
// count of pending error words followed by at most one final word. A byte
// that gives one result or none holds input only while its result waits; a
// byte that breaks an open sequence gives up to four words, drained one per
// cycle, and input is held off until the last of them is taken. Input is
// accepted in the cycle the last pending word leaves, so an unbroken stream
// runs at one byte per cycle with output stalls passed straight back.
module utf8_byte_stream_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [u8bsd_pkg::ByteW-1:0]   data_byte_i,
  input  wire logic                          end_of_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [u8bsd_pkg::CpW-1:0]     code_point_o,
  output logic                               is_error_o,
  output logic      [u8bsd_pkg::CountW-1:0]  byte_count_o,
  output logic                               last_of_run_o
);
  import u8bsd_pkg::*;

  // Sequence state
  logic [CpW-1:0]    partial_q, partial_d;
  logic [CountW-1:0] exp_len_q, exp_len_d;
  logic [CountW-1:0] rcvd_q, rcvd_d;

  // Result register: pending error words, then an optional final word
  logic [CountW-1:0] err_cnt_q, err_cnt_d;
  logic              tail_vld_q, tail_vld_d;
  logic [CpW-1:0]    tail_cp_q, tail_cp_d;
  logic              tail_err_q, tail_err_d;
  logic [CountW-1:0] tail_cnt_q, tail_cnt_d;

  logic              in_fire, out_fire;
  logic              seq_open, is_cont, as_lead;
  logic [CountW-1:0] rcvd_inc;
  logic [CpW-1:0]    partial_shift;

  // Output view of the result register
  always_comb begin
    out_valid_o = (err_cnt_q != LenNone) || tail_vld_q;
    if (err_cnt_q != LenNone) begin
      code_point_o  = '0;
      is_error_o    = 1'b1;
      byte_count_o  = LenOne;
      last_of_run_o = (err_cnt_q == LenOne) && !tail_vld_q;
    end else begin
      code_point_o  = tail_cp_q;
      is_error_o    = tail_err_q;
      byte_count_o  = tail_cnt_q;
      last_of_run_o = 1'b1;
    end
  end

  assign out_fire   = out_valid_o && out_ready_i;
  assign in_ready_o = !out_valid_o || (out_ready_i && last_of_run_o);
  assign in_fire    = in_valid_i && in_ready_o;

  assign seq_open      = (exp_len_q != LenNone);
  assign is_cont       = (data_byte_i[7:6] == ContTag);
  assign rcvd_inc      = rcvd_q + LenOne;
  assign partial_shift = {partial_q[CpW-7:0], data_byte_i[5:0]};

  // Decode one byte against the open sequence
  always_comb begin
    partial_d  = partial_q;
    exp_len_d  = exp_len_q;
    rcvd_d     = rcvd_q;
    err_cnt_d  = LenNone;
    tail_vld_d = 1'b0;
    tail_cp_d  = '0;
    tail_err_d = 1'b0;
    tail_cnt_d = LenOne;
    as_lead    = 1'b1;

    if (seq_open) begin
      if (is_cont) begin
        as_lead   = 1'b0;
        partial_d = partial_shift;
        rcvd_d    = rcvd_inc;
        if (rcvd_inc >= exp_len_q) begin
          tail_vld_d = 1'b1;
          tail_cp_d  = partial_shift;
          tail_cnt_d = exp_len_q;
          partial_d  = '0;
          exp_len_d  = LenNone;
          rcvd_d     = LenNone;
        end else if (end_of_data_i) begin
          err_cnt_d = rcvd_inc;
          partial_d = '0;
          exp_len_d = LenNone;
          rcvd_d    = LenNone;
        end
      end else begin
        // Drop the broken sequence, one error per byte held
        err_cnt_d = rcvd_q;
        partial_d = '0;
        exp_len_d = LenNone;
        rcvd_d    = LenNone;
      end
    end

    if (as_lead) begin
      if (data_byte_i < 8'd128) begin
        tail_vld_d = 1'b1;
        tail_cp_d  = {{(CpW-ByteW){1'b0}}, data_byte_i};
      end else if (data_byte_i < LeadTwoLo || data_byte_i >= LeadBadLo) begin
        tail_vld_d = 1'b1;
        tail_err_d = 1'b1;
      end else begin
        if (data_byte_i < LeadThreeLo) begin
          exp_len_d = LenTwo;
          partial_d = {{(CpW-5){1'b0}}, data_byte_i[4:0]};
        end else if (data_byte_i < LeadFourLo) begin
          exp_len_d = LenThree;
          partial_d = {{(CpW-4){1'b0}}, data_byte_i[3:0]};
        end else begin
          exp_len_d = LenFour;
          partial_d = {{(CpW-3){1'b0}}, data_byte_i[2:0]};
        end
        rcvd_d = LenOne;
        // Truncated at the lead: one error and close
        if (end_of_data_i) begin
          tail_vld_d = 1'b1;
          tail_err_d = 1'b1;
          partial_d  = '0;
          exp_len_d  = LenNone;
          rcvd_d     = LenNone;
        end
      end
    end
  end

  // Sequence state and result counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q  <= '0;
      exp_len_q  <= LenNone;
      rcvd_q     <= LenNone;
      err_cnt_q  <= LenNone;
      tail_vld_q <= 1'b0;
    end else if (in_fire) begin
      partial_q  <= partial_d;
      exp_len_q  <= exp_len_d;
      rcvd_q     <= rcvd_d;
      err_cnt_q  <= err_cnt_d;
      tail_vld_q <= tail_vld_d;
    end else if (out_fire) begin
      // Advance through the pending words
      if (err_cnt_q != LenNone) begin
        err_cnt_q <= err_cnt_q - LenOne;
      end else begin
        tail_vld_q <= 1'b0;
      end
    end
  end

  // Final word payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tail_cp_q  <= tail_cp_d;
      tail_err_q <= tail_err_d;
      tail_cnt_q <= tail_cnt_d;
    end
  end

endmodule : utf8_byte_stream_decoder

`default_nettype wire

// ===== sim/utf8_byte_stream_decoder_tb.sv =====
// Self-checking testbench for the UTF-8 byte stream decoder.
`timescale 1ns / 100ps

module utf8_byte_stream_decoder_tb;
  import u8bsd_pkg::*;

  localparam int unsigned PhaseBytes  = 110;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned WatchdogMax = 5000;

  typedef enum logic [1:0] {
    IdleNone,
    IdleSend,
    IdleRecv,
    IdleBoth
  } idle_mode_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             eod;
  } byte_word_t;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic              is_error;
    logic [CountW-1:0] byte_count;
    logic              last_of_run;
  } cp_word_t;

  localparam cp_word_t ErrWord = cp_word_t'{'0, 1'b1, LenOne, 1'b0};

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [ByteW-1:0]  data_byte_i   = '0;
  logic              end_of_data_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [CpW-1:0]    code_point_o;
  logic              is_error_o;
  logic [CountW-1:0] byte_count_o;
  logic              last_of_run_o;

  byte_word_t  pending_bytes[$];
  cp_word_t    expected_words[$];
  idle_mode_e  idle_mode = IdleNone;
  int unsigned fail_count = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  // Decoder state as the predictor sees it
  logic [CpW-1:0]    seq_payload = '0;
  logic [CountW-1:0] seq_len     = LenNone;
  logic [CountW-1:0] seq_held    = '0;

  utf8_byte_stream_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .end_of_data_i(end_of_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_point_o (code_point_o),
    .is_error_o   (is_error_o),
    .byte_count_o (byte_count_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Work out the words one accepted byte gives and queue them
  function automatic void decode_byte(logic [ByteW-1:0] b, logic eod);
    cp_word_t run[$];
    logic     as_lead;
    as_lead = 1'b1;
    if (seq_len != LenNone) begin
      if (b[7:6] == ContTag) begin
        as_lead = 1'b0;
        seq_payload = {seq_payload[CpW-7:0], b[5:0]};
        seq_held = seq_held + LenOne;
        if (seq_held >= seq_len) begin
          run.push_back(cp_word_t'{seq_payload, 1'b0, seq_len, 1'b0});
          seq_len = LenNone;
        end else if (eod) begin
          repeat (seq_held) run.push_back(ErrWord);
          seq_len = LenNone;
        end
      end else begin
        // broken sequence: one error per byte held, then retry as a lead
        repeat (seq_held) run.push_back(ErrWord);
        seq_len = LenNone;
      end
    end
    if (as_lead) begin
      if (!b[7]) begin
        run.push_back(cp_word_t'{CpW'(b), 1'b0, LenOne, 1'b0});
      end else if (b < LeadTwoLo || b >= LeadBadLo) begin
        run.push_back(ErrWord);
      end else begin
        if (b < LeadThreeLo) begin
          seq_len = LenTwo;
          seq_payload = CpW'(b[4:0]);
        end else if (b < LeadFourLo) begin
          seq_len = LenThree;
          seq_payload = CpW'(b[3:0]);
        end else begin
          seq_len = LenFour;
          seq_payload = CpW'(b[2:0]);
        end
        seq_held = LenOne;
        if (eod) begin
          run.push_back(ErrWord);
          seq_len = LenNone;
        end
      end
    end
    if (run.size() != 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) expected_words.push_back(run[i]);
  endfunction

  function automatic logic send_gap();
    case (idle_mode)
      IdleSend: return $urandom_range(0, 99) < 52;
      IdleBoth: return $urandom_range(0, 99) < 18;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic logic recv_stall();
    case (idle_mode)
      IdleRecv: return $urandom_range(0, 99) < 52;
      IdleBoth: return $urandom_range(0, 99) < 18;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic void queue_byte(logic [ByteW-1:0] b, logic eod);
    pending_bytes.push_back(byte_word_t'{b, eod});
  endfunction

  function automatic logic rare_eod();
    return $urandom_range(0, 99) < 4;
  endfunction

  function automatic logic [ByteW-1:0] random_lead(int unsigned len);
    case (len)
      1:       return ByteW'($urandom_range(0, 127));
      2:       return ByteW'($urandom_range(LeadTwoLo, LeadThreeLo - 1));
      3:       return ByteW'($urandom_range(LeadThreeLo, LeadFourLo - 1));
      default: return ByteW'($urandom_range(LeadFourLo, LeadBadLo - 1));
    endcase
  endfunction

  // Queue a well-formed character, a broken sequence or a random byte
  function automatic int unsigned queue_piece();
    int unsigned len;
    int unsigned conts;
    int unsigned pick;
    logic [ByteW-1:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      queue_byte(ByteW'($urandom), rare_eod());
      return 1;
    end
    len = (pick < 85) ? $urandom_range(1, 4) : $urandom_range(2, 4);
    conts = (pick < 85) ? len - 1 : $urandom_range(1, len - 1) - 1;
    queue_byte(random_lead(len), rare_eod());
    repeat (conts) queue_byte({ContTag, 6'($urandom)}, rare_eod());
    if (pick < 85) return conts + 1;
    do b = ByteW'($urandom); while (b[7:6] == ContTag);
    queue_byte(b, rare_eod());
    return conts + 2;
  endfunction

  // Drive the next pending byte; predict on acceptance
  always @(posedge clk_i) begin
    byte_word_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) decode_byte(data_byte_i, end_of_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_bytes.size() != 0 && !send_gap()) begin
          w = pending_bytes.pop_front();
          in_valid_i    <= 1'b1;
          data_byte_i   <= w.data;
          end_of_data_i <= w.eod;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Count down a long output hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
    end
  end

  // Check each accepted word against the oldest expectation
  always @(posedge clk_i) begin
    cp_word_t got;
    cp_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {code_point_o, is_error_o, byte_count_o, last_of_run_o};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word cp=%h err=%b cnt=%0d last=%b", $time,
                   got.code_point, got.is_error, got.byte_count, got.last_of_run);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected cp=%h err=%b cnt=%0d last=%b, got cp=%h err=%b cnt=%0d last=%b",
                     $time, want.code_point, want.is_error, want.byte_count, want.last_of_run,
                     got.code_point, got.is_error, got.byte_count, got.last_of_run);
            fail_count++;
          end
        end
      end
      out_ready_i <= (hold_left == 0) && !recv_stall();
    end
  end

  // End the run if neither side moves a word for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogMax) begin
        $display("%0t: no progress for %0d cycles", $time, WatchdogMax);
        $display("** utf8_byte_stream_decoder: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Hold the sender back until every queued byte is in and every word out
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic random_phase(idle_mode_e m, logic with_hold);
    int unsigned n;
    n = 0;
    idle_mode = m;
    while (n < PhaseBytes) n += queue_piece();
    if (with_hold) hold_req++;
    wait_drained();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ASCII extremes, stray continuation, bad leads
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7f, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'hf8, 1'b0);
    // complete sequences of two, three and four bytes, the last at the top value
    queue_byte(8'hc2, 1'b0);
    queue_byte(8'ha9, 1'b0);
    queue_byte(8'hef, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'hf7, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'hbf, 1'b0);
    // four-byte sequence broken by ASCII after three bytes: four words at once
    queue_byte(8'hf0, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h41, 1'b0);
    // end of data inside a sequence, on a lead, and on a plain byte
    queue_byte(8'he1, 1'b0);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'hc3, 1'b1);
    queue_byte(8'h00, 1'b1);
    // open sequence broken by a bad lead
    queue_byte(8'hdf, 1'b0);
    queue_byte(8'hff, 1'b0);
    wait_drained();

    random_phase(IdleNone, 1'b1);
    random_phase(IdleSend, 1'b0);
    random_phase(IdleRecv, 1'b0);
    random_phase(IdleBoth, 1'b0);

    repeat (TailCycles) @(negedge clk_i);
    if (expected_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** utf8_byte_stream_decoder: PASSED **");
    end else begin
      $display("** utf8_byte_stream_decoder: FAILED **");
    end
    $finish;
  end

endmodule
